>>> src/decimating_averager_ring_fifo_top_defines.svh
`ifndef DECIMATING_AVERAGER_RING_FIFO_TOP_DEFINES_SVH
`define DECIMATING_AVERAGER_RING_FIFO_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define DAR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define DAR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/dar_pkg.sv
`timescale 1ns / 1ps

package dar_pkg;

    localparam int SmpW   = 16;
    localparam int SumW   = 20;
    localparam int MagW   = 19;
    localparam int DivW   = 4;
    localparam int RmaxW  = 7;
    localparam int StepW  = 5;
    localparam int StatW  = 2;
    localparam int InDataW  = 40;
    localparam int InUserW  = 2;
    localparam int CfgIdxW  = 1;

    localparam logic [StepW-1:0] DivLastStep = StepW'(MagW - 1);

    localparam logic [StatW-1:0] StSample     = 2'd0;
    localparam logic [StatW-1:0] StEmptyRec   = 2'd1;
    localparam logic [StatW-1:0] StEmptyStop  = 2'd2;
    localparam logic [StatW-1:0] StOverflow   = 2'd3;

    localparam logic [CfgIdxW-1:0] CfgDivisor   = 1'd0;
    localparam logic [CfgIdxW-1:0] CfgRecording = 1'd1;

    typedef struct packed {
        logic take;
        logic acc;
        logic div_step;
        logic wr;
        logic chk;
        logic rd;
        logic smp_load;
        logic emit_load;
    } t_cmd;

    typedef struct packed {
        logic acc_div;
        logic acc_ovf;
        logic div_last;
        logic empty;
        logic left_one;
        logic out_free;
    } t_stat;

endpackage

>>> src/dar_ctrl.sv
`timescale 1ns / 1ps

module dar_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_op,
    input  dar_pkg::t_stat i_stat,
    output dar_pkg::t_cmd  o_cmd,
    output logic          o_in_ready
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ACC   = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_WR    = 8'b0000_1000,
        S_RCHK  = 8'b0001_0000,
        S_RADDR = 8'b0010_0000,
        S_ROUT  = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = i_in_op ? S_RCHK : S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                priority if (i_stat.acc_div) begin
                    n_state = S_DIV;
                end else if (i_stat.acc_ovf) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                n_state  = S_IDLE;
            end
            S_RCHK: begin
                o_cmd.chk = 1'b1;
                n_state   = i_stat.empty ? S_EMIT : S_RADDR;
            end
            S_RADDR: begin
                o_cmd.rd = 1'b1;
                n_state  = S_ROUT;
            end
            S_ROUT: begin
                if (i_stat.out_free) begin
                    o_cmd.smp_load = 1'b1;
                    n_state        = i_stat.left_one ? S_IDLE : S_RADDR;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/dar_dpath.sv
`timescale 1ns / 1ps

module dar_dpath #(
    parameter int RING_DEPTH = 4096,
    parameter int MAX_READ   = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dar_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [dar_pkg::DivW-1:0]      i_cfg_data,
    input  logic [dar_pkg::InDataW-1:0]   i_in_data,
    input  logic [dar_pkg::InUserW-1:0]   i_in_user,
    input  dar_pkg::t_cmd                 i_cmd,
    output dar_pkg::t_stat                o_stat,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [dar_pkg::SmpW-1:0]      o_out_sample,
    output logic [dar_pkg::StatW-1:0]     o_out_status,
    output logic                          o_out_last
);

    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int LW = $clog2(MAX_READ + 1);
    localparam logic [PW-1:0]              PtrLast = PW'(RING_DEPTH - 1);
    localparam logic [PW:0]                DepthW  = (PW + 1)'(RING_DEPTH);
    localparam logic [dar_pkg::RmaxW-1:0]  MaxRd   = dar_pkg::RmaxW'(MAX_READ);

    logic [dar_pkg::SmpW-1:0] r_mem [RING_DEPTH];

    logic [dar_pkg::DivW-1:0]  r_divisor;
    logic                      r_recording;
    logic [dar_pkg::SmpW-1:0]  r_in_smp;
    logic                      r_in_fob;
    logic [dar_pkg::RmaxW-1:0] r_in_rmax;
    logic [PW-1:0]             r_wp;
    logic [PW-1:0]             r_rp;
    logic [dar_pkg::SumW-1:0]  r_sum;
    logic [dar_pkg::DivW-1:0]  r_cnt;
    logic                      r_drop;
    logic [dar_pkg::MagW-1:0]  r_dq;
    logic [dar_pkg::DivW-1:0]  r_rem;
    logic [dar_pkg::DivW-1:0]  r_dd;
    logic                      r_neg;
    logic [dar_pkg::StepW-1:0] r_step;
    logic [LW-1:0]             r_left;
    logic [dar_pkg::StatW-1:0] r_emit_st;
    logic [dar_pkg::SmpW-1:0]  r_rd_data;
    logic                      r_out_valid;
    logic [dar_pkg::SmpW-1:0]  r_out_sample;
    logic [dar_pkg::StatW-1:0] r_out_status;
    logic                      r_out_last;

    logic [dar_pkg::DivW-1:0]  d_eff;
    logic                      drop_eff;
    logic [dar_pkg::SumW-1:0]  sum_base;
    logic [dar_pkg::DivW-1:0]  cnt_base;
    logic [dar_pkg::SumW-1:0]  sum_new;
    logic [dar_pkg::DivW-1:0]  cnt_new;
    logic [dar_pkg::SumW-1:0]  sum_abs;
    logic                      complete;
    logic [PW-1:0]             wp_next;
    logic [PW-1:0]             rp_next;
    logic                      full;
    logic [dar_pkg::DivW:0]    rem_sh;
    logic                      rem_ge;
    logic [dar_pkg::DivW:0]    rem_sub;
    logic [dar_pkg::SumW-1:0]  quo_signed;
    logic [PW:0]               span;
    logic [dar_pkg::RmaxW-1:0] lim;
    logic [PW:0]               len;
    logic                      out_free;

    always_comb begin
        d_eff    = (r_divisor == '0) ? dar_pkg::DivW'(1) : r_divisor;
        drop_eff = r_in_fob ? 1'b0 : r_drop;
        sum_base = r_in_fob ? '0 : r_sum;
        cnt_base = r_in_fob ? '0 : r_cnt;
        sum_new  = sum_base + {{(dar_pkg::SumW - dar_pkg::SmpW){r_in_smp[dar_pkg::SmpW-1]}},
                               r_in_smp};
        cnt_new  = cnt_base + dar_pkg::DivW'(1);
        sum_abs  = sum_new[dar_pkg::SumW-1] ? (~sum_new + dar_pkg::SumW'(1)) : sum_new;
        complete = !drop_eff && (cnt_new >= d_eff);
        wp_next  = (r_wp == PtrLast) ? '0 : r_wp + PW'(1);
        rp_next  = (r_rp == PtrLast) ? '0 : r_rp + PW'(1);
        full     = (wp_next == r_rp);

        rem_sh   = {r_rem, r_dq[dar_pkg::MagW-1]};
        rem_ge   = (rem_sh >= {1'b0, r_dd});
        rem_sub  = rem_sh - {1'b0, r_dd};
        quo_signed = r_neg ? (~{1'b0, r_dq} + dar_pkg::SumW'(1)) : {1'b0, r_dq};

        span = (r_rp > r_wp) ? (DepthW - {1'b0, r_rp}) : ({1'b0, r_wp} - {1'b0, r_rp});
        priority if (r_in_rmax == '0) begin
            lim = dar_pkg::RmaxW'(1);
        end else if (r_in_rmax > MaxRd) begin
            lim = MaxRd;
        end else begin
            lim = r_in_rmax;
        end
        len = (span > (PW + 1)'(lim)) ? (PW + 1)'(lim) : span;

        out_free = !r_out_valid || i_out_ready;

        o_stat.acc_div  = complete && !full;
        o_stat.acc_ovf  = complete && full;
        o_stat.div_last = (r_step == dar_pkg::DivLastStep);
        o_stat.empty    = (r_wp == r_rp);
        o_stat.left_one = (r_left == LW'(1));
        o_stat.out_free = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor   <= dar_pkg::DivW'(1);
            r_recording <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dar_pkg::CfgDivisor:   r_divisor   <= i_cfg_data;
                dar_pkg::CfgRecording: r_recording <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_in_smp  <= i_in_data[31:16];
            r_in_fob  <= i_in_user[1];
            r_in_rmax <= i_in_data[38:32];
        end
        if (i_cmd.acc) begin
            r_dq      <= sum_abs[dar_pkg::MagW-1:0];
            r_neg     <= sum_new[dar_pkg::SumW-1];
            r_dd      <= d_eff;
            r_rem     <= '0;
            r_step    <= '0;
            r_emit_st <= dar_pkg::StOverflow;
        end
        if (i_cmd.div_step) begin
            r_dq   <= {r_dq[dar_pkg::MagW-2:0], rem_ge};
            r_rem  <= rem_ge ? rem_sub[dar_pkg::DivW-1:0] : rem_sh[dar_pkg::DivW-1:0];
            r_step <= r_step + dar_pkg::StepW'(1);
        end
        if (i_cmd.chk) begin
            r_left    <= LW'(len);
            r_emit_st <= r_recording ? dar_pkg::StEmptyRec : dar_pkg::StEmptyStop;
        end
        if (i_cmd.smp_load) begin
            r_left <= r_left - LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[r_wp] <= quo_signed[dar_pkg::SmpW-1:0];
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_sum  <= '0;
            r_cnt  <= '0;
            r_drop <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                priority if (drop_eff) begin
                    r_sum  <= sum_base;
                    r_cnt  <= cnt_base;
                    r_drop <= 1'b1;
                end else if (complete) begin
                    r_sum  <= '0;
                    r_cnt  <= '0;
                    r_drop <= full;
                end else begin
                    r_sum  <= sum_new;
                    r_cnt  <= cnt_new;
                    r_drop <= 1'b0;
                end
            end
            if (i_cmd.wr) begin
                r_wp <= wp_next;
            end
            if (i_cmd.rd) begin
                r_rp <= rp_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.smp_load || i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.smp_load) begin
            r_out_sample <= r_rd_data;
            r_out_status <= dar_pkg::StSample;
            r_out_last   <= (r_left == LW'(1));
        end else if (i_cmd.emit_load) begin
            r_out_sample <= '0;
            r_out_status <= r_emit_st;
            r_out_last   <= 1'b1;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

endmodule

>>> src/decimating_averager_ring_fifo_top.sv
`timescale 1ns / 1ps
// Boxcar decimator feeding a ring FIFO of RING_DEPTH 16-bit entries.
// Input stream: tuser[0] picks a codec word (0) or a read request (1);
// tuser[1] marks the first word of a block. tdata[31:16] is the sample.
// Output stream: one word per sample read, or one status word (empty or
// overflow); tlast marks the final word caused by an input word.
// Configuration: i_cfg_we with index 0 = divisor, 1 = recording.
// One input word is in work at a time; s_axis_tready is high only in idle.
// A codec word that completes a group with room in the ring runs accumulate,
// the bit-serial divider (19 steps) and the ring write; one that completes
// a group in a full ring goes from accumulate to load its overflow status;
// any other codec word returns to idle after accumulate.
// A read request runs a length check, then for each sample a ring read and
// then an output load; an empty read goes from the length check to loading
// its status word.
// A stalled sink holds the output register; the block waits before loading
// the next result and accepts no further input word until done.
// Reset clears pointers, group and drop state; ring contents are undefined
// until written and are never read before that.

`include "decimating_averager_ring_fifo_top_defines.svh"

module decimating_averager_ring_fifo_top #(
    parameter int RING_DEPTH = 4096,
    parameter int MAX_READ   = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [dar_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [dar_pkg::DivW-1:0]    i_cfg_data,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // data_word [31:0], read_max [38:32], zero [39]
    input  logic [dar_pkg::InDataW-1:0] i_s_axis_tdata,
    // opcode [0], first_of_block [1]
    input  logic [dar_pkg::InUserW-1:0] i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // sample [15:0]
    output logic [dar_pkg::SmpW-1:0]    o_m_axis_tdata,
    // status [1:0]
    output logic [dar_pkg::StatW-1:0]   o_m_axis_tuser,
    output logic                        o_m_axis_tlast
);

    dar_pkg::t_cmd  w_cmd;
    dar_pkg::t_stat w_stat;

    dar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_op    (i_s_axis_tuser[0]),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (o_s_axis_tready)
    );

    dar_dpath #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_READ   (MAX_READ)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_data    (i_s_axis_tdata),
        .i_in_user    (i_s_axis_tuser),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_sample (o_m_axis_tdata),
        .o_out_status (o_m_axis_tuser),
        .o_out_last   (o_m_axis_tlast)
    );

    `DAR_ASSERT_NEXT(a_one_word_in_work, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "second word taken while busy")
    `DAR_ASSERT_NOW(a_status_word_is_final, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tuser != dar_pkg::StSample),
        o_m_axis_tlast && (o_m_axis_tdata == '0), "status word not final or sample not zero")
    `DAR_ASSERT_NOW(a_load_only_when_busy, i_clk, i_rst_n,
        w_cmd.smp_load || w_cmd.emit_load, !o_s_axis_tready && w_stat.out_free,
        "result loaded while idle or while output held")

endmodule
